// File: hdl/sqjd_pkg.sv
package sqjd_pkg;

    localparam int QUEUE_DEPTH = 3;
    localparam int NSRV = 2;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SLOT_W = $clog2(QUEUE_DEPTH * NSRV);

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_ARRIVE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SRV,
        ST_DISP,
        ST_ARR,
        ST_EMIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [15:0] id;
        logic [31:0] arrival;
        logic [31:0] duration;
        logic [31:0] deadline;
    } job_t;

    typedef struct packed {
        logic [15:0] id;
        logic [1:0]  server;
        logic        outcome;
        logic [31:0] event_time;
        logic [31:0] delay;
    } result_t;

endpackage

// File: hdl/shortest_queue_job_dispatcher.sv
// channel | direction | handshake   | payload
// in      | input     | valid/stall | opcode job_id duration deadline
// out     | output    | valid/stall | out_job_id server outcome event_time delay last
// cfg     | input     | valid/ready | cfg_data (servers_in_use)
// One sequencer walks servers then queues, one event per cycle unless a held result
// is stalled, and each result waits in a holding register ahead of the output register.
// Reset clears time, fills and busy flags; servers_in_use resets to 2.
// Stall on out holds the sequencer once both result registers are full;
// in_stall is high while an item is in work.
module shortest_queue_job_dispatcher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        opcode,
    input  logic [15:0] job_id,
    input  logic [31:0] duration,
    input  logic [31:0] deadline,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] out_job_id,
    output logic [1:0]  server,
    output logic        outcome,
    output logic [31:0] event_time,
    output logic [31:0] delay,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data
);

    sqjd_pkg::state_t state_reg, state_next;
    logic [1:0]  siu_reg;
    logic [31:0] now_reg, now_next;
    logic        sel_reg, sel_next;
    logic        busy_reg [2];
    logic        busy_next [2];
    sqjd_pkg::job_t run_reg [2];
    sqjd_pkg::job_t run_next [2];
    logic [31:0] start_reg [2];
    logic [31:0] start_next [2];
    sqjd_pkg::job_t arr_reg;
    sqjd_pkg::job_t arr_next;
    logic        op_reg, op_next;

    logic            ov_reg, ov_next;
    sqjd_pkg::result_t or_reg, or_next;
    logic            olast_reg, olast_next;
    logic            pend_reg, pend_next;
    sqjd_pkg::result_t pr_reg, pr_next;

    logic        push, push_q, pop, pop_q;
    sqjd_pkg::job_t head;
    logic [sqjd_pkg::FILL_W-1:0] fill0, fill1, fq;
    logic        emit;
    sqjd_pkg::result_t er;
    logic        q;
    logic [31:0] rem;

    sqjd_queues u_q (
        .clk(clk), .rst_n(rst_n),
        .push(push), .push_q(push_q), .push_job(arr_reg),
        .pop(pop), .pop_q(pop_q), .head_job(head),
        .fill0(fill0), .fill1(fill1)
    );

    assign in_stall  = (state_reg != sqjd_pkg::ST_IDLE);
    assign cfg_ready = (state_reg == sqjd_pkg::ST_IDLE) && !ov_reg && !pend_reg;
    assign out_valid = ov_reg;
    assign out_job_id = or_reg.id;
    assign server = or_reg.server;
    assign outcome = or_reg.outcome;
    assign event_time = or_reg.event_time;
    assign delay = or_reg.delay;
    assign last = olast_reg;

    // out register free to load this cycle
    logic ofree;
    assign ofree = !ov_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        now_next = now_reg;
        sel_next = sel_reg;
        busy_next = busy_reg;
        run_next = run_reg;
        start_next = start_reg;
        arr_next = arr_reg;
        op_next = op_reg;
        ov_next = ov_reg && out_stall;
        or_next = or_reg;
        olast_next = olast_reg;
        pend_next = pend_reg;
        pr_next = pr_reg;
        push = 1'b0;
        push_q = 1'b0;
        pop = 1'b0;
        pop_q = sel_reg;
        emit = 1'b0;
        er = pr_reg;
        q = sel_reg;
        fq = sel_reg ? fill1 : fill0;
        rem = run_reg[sel_reg].duration;
        unique case (state_reg)
            sqjd_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next = opcode;
                    arr_next = '{id: job_id, arrival: now_reg, duration: duration,
                                 deadline: deadline};
                    sel_next = 1'b0;
                    if (opcode == sqjd_pkg::OP_TICK)
                    begin
                        now_next = now_reg + 32'd1;
                        state_next = sqjd_pkg::ST_SRV;
                    end
                    else
                    begin
                        state_next = sqjd_pkg::ST_ARR;
                    end
                end
            end
            sqjd_pkg::ST_ARR:
            begin
                q = (siu_reg == 2'd1) ? 1'b0 : ((fill0 <= fill1) ? 1'b0 : 1'b1);
                fq = q ? fill1 : fill0;
                if (fq >= sqjd_pkg::FILL_W'(sqjd_pkg::QUEUE_DEPTH)
                    || now_reg > arr_reg.deadline)
                begin
                    emit = 1'b1;
                    er = '{id: arr_reg.id, server: 2'd0, outcome: 1'b1,
                           event_time: now_reg, delay: 32'd0};
                    state_next = sqjd_pkg::ST_DONE;
                end
                else
                begin
                    push = 1'b1;
                    push_q = q;
                    sel_next = q;
                    op_next = sqjd_pkg::OP_ARRIVE;
                    state_next = sqjd_pkg::ST_DISP;
                end
            end
            sqjd_pkg::ST_SRV:
            begin
                if (busy_reg[sel_reg])
                begin
                    rem = run_reg[sel_reg].duration;
                    if (rem <= 32'd1)
                    begin
                        emit = 1'b1;
                        er = '{id: run_reg[sel_reg].id, server: {1'b0, 1'b0} + {sel_reg, ~sel_reg},
                               outcome: 1'b0, event_time: now_reg,
                               delay: start_reg[sel_reg] - run_reg[sel_reg].arrival};
                        busy_next[sel_reg] = 1'b0;
                    end
                    else
                    begin
                        run_next[sel_reg].duration = rem - 32'd1;
                        if (run_reg[sel_reg].deadline <= now_reg)
                        begin
                            emit = 1'b1;
                            er = '{id: run_reg[sel_reg].id, server: {sel_reg, ~sel_reg},
                                   outcome: 1'b1, event_time: now_reg,
                                   delay: now_reg - run_reg[sel_reg].arrival};
                            busy_next[sel_reg] = 1'b0;
                        end
                    end
                end
                sel_next = ~sel_reg;
                if (sel_reg)
                begin
                    sel_next = 1'b0;
                    state_next = sqjd_pkg::ST_DISP;
                end
            end
            sqjd_pkg::ST_DISP:
            begin
                if (fq != '0 && !busy_reg[sel_reg])
                begin
                    pop = 1'b1;
                    run_next[sel_reg] = head;
                    start_next[sel_reg] = now_reg;
                    if (head.deadline <= now_reg)
                    begin
                        emit = 1'b1;
                        er = '{id: head.id, server: {sel_reg, ~sel_reg}, outcome: 1'b1,
                               event_time: now_reg, delay: now_reg - head.arrival};
                    end
                    else
                    begin
                        busy_next[sel_reg] = 1'b1;
                    end
                end
                else if (op_reg == sqjd_pkg::OP_ARRIVE || sel_reg)
                begin
                    state_next = sqjd_pkg::ST_DONE;
                end
                else
                begin
                    sel_next = 1'b1;
                end
            end
            sqjd_pkg::ST_DONE:
            begin
                if (ofree && !ov_next)
                begin
                    if (pend_reg)
                    begin
                        ov_next = 1'b1;
                        or_next = pr_reg;
                        olast_next = 1'b1;
                        pend_next = 1'b0;
                    end
                    state_next = sqjd_pkg::ST_IDLE;
                end
            end
            sqjd_pkg::ST_EMIT:
            begin
                state_next = sqjd_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = sqjd_pkg::ST_IDLE;
            end
        endcase
        // held result goes out (not last) once a newer one arrives
        if (emit)
        begin
            if (pend_reg)
            begin
                ov_next = 1'b1;
                or_next = pr_reg;
                olast_next = 1'b0;
            end
            pend_next = 1'b1;
            pr_next = er;
        end
        // stall the sequencer while a held result cannot move
        if (pend_reg && !ofree && state_reg != sqjd_pkg::ST_DONE)
        begin
            state_next = state_reg;
            sel_next = sel_reg;
            busy_next = busy_reg;
            run_next = run_reg;
            start_next = start_reg;
            ov_next = ov_reg;
            or_next = or_reg;
            olast_next = olast_reg;
            pend_next = pend_reg;
            pr_next = pr_reg;
            op_next = op_reg;
            push = 1'b0;
            pop = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sqjd_pkg::ST_IDLE;
            siu_reg <= 2'd2;
            now_reg <= '0;
            sel_reg <= 1'b0;
            busy_reg[0] <= 1'b0;
            busy_reg[1] <= 1'b0;
            ov_reg <= 1'b0;
            pend_reg <= 1'b0;
            op_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                siu_reg <= cfg_data;
            end
            now_reg <= now_next;
            sel_reg <= sel_next;
            busy_reg <= busy_next;
            ov_reg <= ov_next;
            pend_reg <= pend_next;
            op_reg <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        run_reg <= run_next;
        start_reg <= start_next;
        arr_reg <= arr_next;
        or_reg <= or_next;
        olast_reg <= olast_next;
        pr_reg <= pr_next;
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_job_id))
        else $error("result changed under stall");
    a_busy_in: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != sqjd_pkg::ST_IDLE |-> in_stall)
        else $error("input open during work");
    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        fill0 <= sqjd_pkg::FILL_W'(sqjd_pkg::QUEUE_DEPTH)
        && fill1 <= sqjd_pkg::FILL_W'(sqjd_pkg::QUEUE_DEPTH))
        else $error("queue overfilled");
    a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready |-> !pend_reg)
        else $error("config while busy");

endmodule

// File: hdl/sqjd_queues.sv
module sqjd_queues (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   push,
    input  logic                                   push_q,
    input  sqjd_pkg::job_t                         push_job,
    input  logic                                   pop,
    input  logic                                   pop_q,
    output sqjd_pkg::job_t                         head_job,
    output logic [sqjd_pkg::FILL_W-1:0]            fill0,
    output logic [sqjd_pkg::FILL_W-1:0]            fill1
);

    sqjd_pkg::job_t                mem_reg [sqjd_pkg::NSRV][sqjd_pkg::QUEUE_DEPTH];
    logic [sqjd_pkg::FILL_W-1:0]   fill_reg [sqjd_pkg::NSRV];

    assign fill0 = fill_reg[0];
    assign fill1 = fill_reg[1];
    assign head_job = mem_reg[pop_q][0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg[0] <= '0;
            fill_reg[1] <= '0;
        end
        else if (push)
        begin
            fill_reg[push_q] <= fill_reg[push_q] + sqjd_pkg::FILL_W'(1);
        end
        else if (pop)
        begin
            fill_reg[pop_q] <= fill_reg[pop_q] - sqjd_pkg::FILL_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[push_q][fill_reg[push_q][sqjd_pkg::FILL_W-1:0]] <= push_job;
        end
        else if (pop)
        begin
            for (int i = 0; i + 1 < sqjd_pkg::QUEUE_DEPTH; i++)
            begin
                mem_reg[pop_q][i] <= mem_reg[pop_q][i+1];
            end
        end
    end

endmodule

// File: dv/shortest_queue_job_dispatcher_tb.sv
module shortest_queue_job_dispatcher_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [15:0] id;
        logic [1:0]  srv;
        logic        outc;
        logic [31:0] etime;
        logic [31:0] dly;
        logic        lst;
    } report_t;

    typedef struct {
        logic        op;
        logic [15:0] id;
        logic [31:0] dur;
        logic [31:0] dl;
        bit          typed;
        report_t     want;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        opcode;
    logic [15:0] job_id;
    logic [31:0] duration;
    logic [31:0] deadline;
    logic        out_valid;
    logic        out_stall;
    logic [15:0] out_job_id;
    logic [1:0]  server;
    logic        outcome;
    logic [31:0] event_time;
    logic [31:0] delay;
    logic        last;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_data;

    shortest_queue_job_dispatcher u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .opcode(opcode), .job_id(job_id),
        .duration(duration), .deadline(deadline),
        .out_valid(out_valid), .out_stall(out_stall), .out_job_id(out_job_id),
        .server(server), .outcome(outcome), .event_time(event_time), .delay(delay),
        .last(last), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    // dispatcher shadow state
    logic [31:0]     now_t;
    sqjd_pkg::job_t  fifo [2][sqjd_pkg::QUEUE_DEPTH];
    int              fill [2];
    bit              busy [2];
    sqjd_pkg::job_t  run [2];
    logic [31:0]     run_start [2];
    logic [31:0]     left [2];
    logic [1:0]      mode;

    report_t     pending [$];
    report_t     step_out [$];
    int          errors;
    int          send_idle, recv_idle;
    bit          hold_off;

    task automatic note(input logic [15:0] id, input logic [1:0] s, input logic o,
                        input logic [31:0] t, input logic [31:0] d);
        report_t r;
        r = '{id, s, o, t, d, 1'b0};
        step_out.insert(step_out.size(), r);
    endtask

    task automatic pull_jobs(input int q);
        while (fill[q] > 0 && !busy[q])
        begin
            run[q] = fifo[q][0];
            left[q] = fifo[q][0].duration;
            run_start[q] = now_t;
            busy[q] = 1;
            for (int i = 0; i + 1 < fill[q]; i++)
                fifo[q][i] = fifo[q][i+1];
            fill[q]--;
            if (run[q].deadline <= now_t)
            begin
                note(run[q].id, 2'(q + 1), 1'b1, now_t, now_t - run[q].arrival);
                busy[q] = 0;
            end
        end
    endtask

    task automatic predict_dispatch(input logic op, input logic [15:0] id,
                                    input logic [31:0] dur, input logic [31:0] dl);
        int q;
        step_out.delete();
        if (op == sqjd_pkg::OP_TICK)
        begin
            now_t++;
            for (int s = 0; s < 2; s++)
            begin
                if (busy[s])
                begin
                    if (left[s] <= 1)
                    begin
                        left[s] = 0;
                        note(run[s].id, 2'(s + 1), 1'b0, now_t,
                             run_start[s] - run[s].arrival);
                        busy[s] = 0;
                    end
                    else
                    begin
                        left[s]--;
                        if (run[s].deadline <= now_t)
                        begin
                            note(run[s].id, 2'(s + 1), 1'b1, now_t,
                                 now_t - run[s].arrival);
                            busy[s] = 0;
                        end
                    end
                end
            end
            pull_jobs(0);
            pull_jobs(1);
        end
        else
        begin
            q = (mode == 2'd1) ? 0 : ((fill[0] <= fill[1]) ? 0 : 1);
            if (fill[q] >= sqjd_pkg::QUEUE_DEPTH || now_t > dl)
            begin
                note(id, 2'd0, 1'b1, now_t, 32'd0);
            end
            else
            begin
                fifo[q][fill[q]] = '{id, now_t, dur, dl};
                fill[q]++;
                pull_jobs(q);
            end
        end
        if (step_out.size() > 0)
            step_out[step_out.size()-1].lst = 1'b1;
    endtask

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("[shortest_queue_job_dispatcher] ERROR");
        $finish;
    end

    // receiver
    always @(negedge clk)
    begin
        if (hold_off)
            out_stall <= 1'b1;
        else
            out_stall <= ($urandom_range(99) < recv_idle);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            report_t got, exp;
            got = '{out_job_id, server, outcome, event_time, delay, last};
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected transfer %p", $time, got);
                errors++;
            end
            else
            begin
                exp = pending.pop_front();
                if (got !== exp)
                begin
                    $display("%0t: expected %p, actual %p", $time, exp, got);
                    errors++;
                end
            end
        end
    end

    task automatic send(input logic op, input logic [15:0] id, input logic [31:0] dur,
                        input logic [31:0] dl);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        job_id <= id;
        duration <= dur;
        deadline <= dl;
        do @(posedge clk); while (in_stall);
        predict_dispatch(op, id, dur, dl);
        foreach (step_out[i]) pending.insert(pending.size(), step_out[i]);
        @(negedge clk);
    endtask

    task automatic write_mode(input logic [1:0] v);
        int n;
        n = 0;
        in_valid <= 1'b0;
        while (pending.size() != 0 && n < 200000)
        begin
            @(negedge clk);
            n++;
        end
        repeat (12) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        mode = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_job();
        logic [31:0] dur, dl;
        int k;
        k = $urandom_range(9);
        dur = (k == 0) ? $urandom() : ((k == 1) ? 32'd0 : 32'($urandom_range(1, 6)));
        k = $urandom_range(9);
        dl = (k == 0) ? $urandom() : ((k == 1) ? 32'hFFFF_FFFF :
             now_t + 32'($urandom_range(0, 10)) - 32'($urandom_range(0, 2)));
        send(sqjd_pkg::OP_ARRIVE, 16'($urandom()), dur, dl);
    endtask

    initial
    begin
        row_t rows [$];
        int   n;
        errors = 0; hold_off = 0; send_idle = 0; recv_idle = 0;
        in_valid = 0; opcode = 0; job_id = 0; duration = 0; deadline = 0;
        cfg_valid = 0; cfg_data = 2'd2; out_stall = 0;
        now_t = 0; fill = '{0, 0}; busy = '{0, 0}; mode = 2'd2;
        rst_n = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        rows.insert(rows.size(), '{sqjd_pkg::OP_ARRIVE, 16'hFFFF, 32'd3, 32'd0, 1,
                                   '{16'hFFFF, 2'd1, 1'b1, 32'd0, 32'd0, 1'b1}});
        rows.insert(rows.size(), '{sqjd_pkg::OP_TICK, 16'd0, 32'd0, 32'd0, 0, '0});
        rows.insert(rows.size(), '{sqjd_pkg::OP_ARRIVE, 16'h0001, 32'd0, 32'd0, 1,
                                   '{16'h0001, 2'd0, 1'b1, 32'd1, 32'd0, 1'b1}});
        rows.insert(rows.size(), '{sqjd_pkg::OP_ARRIVE, 16'h0002, 32'hFFFF_FFFF,
                                   32'hFFFF_FFFF, 0, '0});
        rows.insert(rows.size(), '{sqjd_pkg::OP_ARRIVE, 16'h0003, 32'd0, 32'hFFFF_FFFF,
                                   0, '0});
        for (int i = 0; i < 6; i++)
            rows.insert(rows.size(), '{sqjd_pkg::OP_ARRIVE, 16'(16'h10 + i), 32'd2, 32'd3,
                                       0, '0});
        rows.insert(rows.size(), '{sqjd_pkg::OP_ARRIVE, 16'h0000, 32'd1, 32'd9, 0, '0});
        for (int i = 0; i < 6; i++)
            rows.insert(rows.size(), '{sqjd_pkg::OP_TICK, 16'd0, 32'd0, 32'd0, 0, '0});
        foreach (rows[i])
        begin
            send(rows[i].op, rows[i].id, rows[i].dur, rows[i].dl);
            if (rows[i].typed && (step_out.size() != 1 || step_out[0] !== rows[i].want))
            begin
                $display("%0t: expected %p, actual %p", $time, rows[i].want, step_out[0]);
                errors++;
            end
        end

        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle = (ph == 0) ? 28 : ((ph == 1) ? 63 : 0);
            recv_idle = (ph == 0) ? 63 : ((ph == 1) ? 28 : 0);
            write_mode(ph == 0 ? 2'd1 : (ph == 1 ? 2'd3 : 2'd0));
            if (ph == 2)
            begin
                fork
                    begin
                        hold_off = 1;
                        repeat (300) @(negedge clk);
                        hold_off = 0;
                    end
                    for (int i = 0; i < 12; i++)
                        if (i % 2) send(sqjd_pkg::OP_TICK, 16'd0, 32'd0, 32'd0);
                        else random_job();
                join
            end
            n = 0;
            while (n < 58)
            begin
                if ($urandom_range(1)) random_job();
                else send(sqjd_pkg::OP_TICK, 16'd0, 32'd0, 32'd0);
                n++;
            end
        end
        write_mode(2'd2);
        for (int i = 0; i < 8; i++) send(sqjd_pkg::OP_TICK, 16'd0, 32'd0, 32'd0);
        in_valid <= 1'b0;

        n = 0;
        while (pending.size() != 0 && n < 200000)
        begin
            @(posedge clk);
            n++;
        end
        repeat (20) @(posedge clk);
        if (errors == 0 && pending.size() == 0)
            $display("[shortest_queue_job_dispatcher] OK");
        else
            $display("[shortest_queue_job_dispatcher] ERROR");
        $finish;
    end
endmodule

// File: files.f
hdl/sqjd_pkg.sv
hdl/sqjd_queues.sv
hdl/shortest_queue_job_dispatcher.sv
dv/shortest_queue_job_dispatcher_tb.sv
